[rtl/core/variable_feedback_delay_line_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef VARIABLE_FEEDBACK_DELAY_LINE_MACROS_SVH
`define VARIABLE_FEEDBACK_DELAY_LINE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define VFDL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("vfdl: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define VFDL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("vfdl: next-cycle check failed");

`endif

[rtl/core/vfdl_pkg.sv]
package vfdl_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int FRAC_W     = 8;
    localparam int DELAY_W    = 20;
    localparam int LEN_W      = 13;
    localparam int GAIN_W     = 16;
    localparam int GAIN_SHIFT = 15;

    localparam int S_TDATA_W  = ((SAMPLE_W + DELAY_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;

    localparam int CFG_DATA_W = (GAIN_W > LEN_W) ? GAIN_W : LEN_W;
    localparam int CFG_IDX_W  = 1;

    localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(4096);
    localparam logic [GAIN_W-1:0] GAIN_RESET = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_LENGTH   = 1'b0,
        REG_FEEDBACK_GAIN = 1'b1
    } cfg_reg_t;

endpackage

[rtl/core/variable_feedback_delay_line.sv]
// Channel   Direction  tdata / fields (low bit up)
// s_        in         in_sample[15:0], delay_amount[35:16], zero pad [39:36]
// m_        out        out_sample[15:0]
// cfg_      in         index 0 line_length[12:0], index 1 feedback_gain[15:0]
//
// One request is handled at a time; a new one is accepted only after the last
// write-back. One store read port serves both interpolation taps, and a single
// 17x17 multiplier does the interpolation and then the feedback scaling in turn.
// After reset a clearing pass zeroes every store entry; s_tready
// stays low meanwhile. A result held in m_ stalls only the final write-back.
`include "variable_feedback_delay_line_macros.svh"

module variable_feedback_delay_line #(
    parameter int DEPTH = 4096
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // in_sample, delay_amount, zero pad
    input  logic [vfdl_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_sample
    output logic [vfdl_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_we,
    input  logic [vfdl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vfdl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    import vfdl_pkg::*;

    localparam int AW  = $clog2(DEPTH);
    localparam int LW  = ($clog2(DEPTH + 1) > LEN_W) ? $clog2(DEPTH + 1) : LEN_W;
    // r holds ((w + len) << FRAC_W) - d; always at least DELAY_W bits wide
    localparam int RW  = LW + 1 + FRAC_W;
    localparam int MW  = SAMPLE_W + 1;
    localparam int PW  = 2 * MW;
    localparam int XW  = SAMPLE_W + 2;

    localparam logic signed [XW-1:0] ACC_MAX = XW'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [XW-1:0] ACC_MIN = ~ACC_MAX;

    typedef enum logic [3:0] {
        CLEAR, IDLE, CALC_R, CALC_IDX, READ_A, READ_B, MUL_D, SUM_Y, MUL_G, WRITE
    } state_t;

    state_t state_reg, state_next;

    logic [LEN_W-1:0]           line_length_reg;
    logic signed [GAIN_W-1:0]   gain_reg;
    logic [AW-1:0]              clr_cnt_reg;
    logic [AW-1:0]              write_pos_reg;
    logic                       m_tvalid_reg;
    logic [SAMPLE_W-1:0]        m_data_reg;

    logic signed [SAMPLE_W-1:0] x_reg;
    logic [DELAY_W-1:0]         d_reg;
    logic [LW-1:0]              len_reg;
    logic [AW-1:0]              w_reg;
    logic [RW-1:0]              r_reg;
    logic [AW-1:0]              base_reg;
    logic [AW-1:0]              next_reg;
    logic [FRAC_W-1:0]          frac_reg;
    logic signed [SAMPLE_W-1:0] a_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic signed [PW-1:0]       prod_reg;

    logic                       s_fire;
    logic                       out_free;
    logic                       wb_go;
    logic [LW-1:0]              len_cl;
    logic [LW-1:0]              line_ext;
    logic [AW-1:0]              w_eff;
    logic [RW-1:0]              dmax;
    logic [RW-1:0]              d_ext;
    logic [RW-1:0]              d_cl;
    logic [LW:0]                rint;
    logic [LW:0]                base_full;
    logic [LW:0]                next_full;
    logic signed [MW-1:0]       mul_a;
    logic signed [MW-1:0]       mul_b;
    logic signed [PW-1:0]       prod;
    logic signed [PW-1:0]       prod_interp;
    logic signed [PW-1:0]       prod_fb;
    logic signed [XW-1:0]       y_full;
    logic signed [XW-1:0]       acc;
    logic signed [SAMPLE_W-1:0] acc_sat;
    logic [LW:0]                w_inc;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [SAMPLE_W-1:0]        ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [SAMPLE_W-1:0]        ram_rdata;

    assign s_tready = (state_reg == IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_data_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign wb_go    = (state_reg == WRITE) && out_free;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_length_reg <= LEN_RESET;
            gain_reg        <= GAIN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LINE_LENGTH:   line_length_reg <= cfg_wdata[LEN_W-1:0];
                REG_FEEDBACK_GAIN: gain_reg        <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // length clamp and effective write position, taken at accept
    assign line_ext = LW'(line_length_reg);
    always_comb begin
        priority if (line_ext < LW'(2)) begin
            len_cl = LW'(2);
        end else if (line_ext > LW'(DEPTH)) begin
            len_cl = LW'(DEPTH);
        end else begin
            len_cl = line_ext;
        end
    end
    assign w_eff = (LW'(write_pos_reg) >= len_cl) ? '0 : write_pos_reg;

    // read position: r = (w + len) * 2^F - min(d, len * 2^F - 1)
    assign dmax  = (RW'(len_reg) << FRAC_W) - RW'(1);
    assign d_ext = RW'(d_reg);
    assign d_cl  = (d_ext > dmax) ? dmax : d_ext;

    // integer part lies in [0, 2*len), one subtract wraps it
    assign rint      = r_reg[RW-1:FRAC_W];
    assign base_full = (rint >= (LW+1)'(len_reg)) ? rint - (LW+1)'(len_reg) : rint;
    assign next_full = base_full + (LW+1)'(1);

    // shared multiplier
    always_comb begin
        unique case (state_reg)
            MUL_D: begin
                mul_a = MW'($signed(ram_rdata)) - MW'(a_reg);
                mul_b = $signed(MW'(frac_reg));
            end
            MUL_G: begin
                mul_a = MW'(y_reg);
                mul_b = MW'(gain_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign prod = mul_a * mul_b;

    // arithmetic shifts floor towards minus infinity
    assign prod_interp = prod_reg >>> FRAC_W;
    assign prod_fb     = prod_reg >>> GAIN_SHIFT;
    assign y_full      = XW'(a_reg) + prod_interp[XW-1:0];
    assign acc         = XW'(x_reg) + prod_fb[XW-1:0];

    always_comb begin
        priority if (acc > ACC_MAX) begin
            acc_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else if (acc < ACC_MIN) begin
            acc_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            acc_sat = acc[SAMPLE_W-1:0];
        end
    end

    assign w_inc = (LW+1)'(w_reg) + (LW+1)'(1);

    // store ports
    assign ram_we    = (state_reg == CLEAR) || wb_go;
    assign ram_waddr = (state_reg == CLEAR) ? clr_cnt_reg : w_reg;
    assign ram_wdata = (state_reg == CLEAR) ? '0 : acc_sat;
    assign ram_raddr = (state_reg == READ_A) ? base_reg : next_reg;

    vfdl_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CLEAR:    if (clr_cnt_reg == AW'(DEPTH - 1)) state_next = IDLE;
            IDLE:     if (s_fire) state_next = CALC_R;
            CALC_R:   state_next = CALC_IDX;
            CALC_IDX: state_next = READ_A;
            READ_A:   state_next = READ_B;
            READ_B:   state_next = MUL_D;
            MUL_D:    state_next = SUM_Y;
            SUM_Y:    state_next = MUL_G;
            MUL_G:    state_next = WRITE;
            WRITE:    if (out_free) state_next = IDLE;
            default:  state_next = CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= CLEAR;
            clr_cnt_reg   <= '0;
            write_pos_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (wb_go) begin
                write_pos_reg <= (w_inc >= (LW+1)'(len_reg)) ? '0 : w_inc[AW-1:0];
                m_tvalid_reg  <= 1'b1;
                m_data_reg    <= y_reg;
            end else if (m_tready) begin
                m_tvalid_reg  <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            x_reg   <= s_tdata[SAMPLE_W-1:0];
            d_reg   <= s_tdata[SAMPLE_W +: DELAY_W];
            len_reg <= len_cl;
            w_reg   <= w_eff;
        end
        if (state_reg == CALC_R) begin
            r_reg <= (RW'(LW'(w_reg) + len_reg) << FRAC_W) - d_cl;
        end
        if (state_reg == CALC_IDX) begin
            base_reg <= base_full[AW-1:0];
            next_reg <= (next_full == (LW+1)'(len_reg)) ? '0 : next_full[AW-1:0];
            frac_reg <= r_reg[FRAC_W-1:0];
        end
        if (state_reg == READ_B) begin
            a_reg <= ram_rdata;
        end
        if (state_reg == MUL_D || state_reg == MUL_G) begin
            prod_reg <= prod;
        end
        if (state_reg == SUM_Y) begin
            y_reg <= y_full[SAMPLE_W-1:0];
        end
    end

    `VFDL_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
    `VFDL_ASSERT_NOW(a_taps_in_line, state_reg == READ_A,
        (LW'(base_reg) < len_reg) && (LW'(next_reg) < len_reg))
    `VFDL_ASSERT_NOW(a_result_from_wb, $rose(m_tvalid), $past(state_reg == WRITE))

endmodule

[rtl/core/vfdl_ram.sv]
module vfdl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[tb/sv/variable_feedback_delay_line_test.sv]
module variable_feedback_delay_line_test;
    import vfdl_pkg::*;

    localparam int DEPTH       = 4096;
    localparam int CYCLE_LIMIT = 400000;

    // Mirrors the delay line: store, write position and both registers.
    class delay_line_scoreboard;
        logic signed [SAMPLE_W-1:0] taps [DEPTH];
        int unsigned                wr_pos;
        logic [LEN_W-1:0]           line_len;
        logic signed [GAIN_W-1:0]   gain;
        logic [SAMPLE_W-1:0]        pending [$];
        int                         errors;

        function new();
            foreach (taps[i]) taps[i] = '0;
            wr_pos   = 0;
            line_len = LEN_RESET;
            gain     = GAIN_RESET;
            errors   = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                REG_LINE_LENGTH:   line_len = v[LEN_W-1:0];
                REG_FEEDBACK_GAIN: gain = v[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        function longint eff_len();
            longint len;
            len = line_len;
            if (len < 2) len = 2;
            if (len > DEPTH) len = DEPTH;
            return len;
        endfunction

        // Interpolated read, then feedback write-back with saturation.
        function void note_request(logic signed [SAMPLE_W-1:0] x, logic [DELAY_W-1:0] d_raw);
            longint len, w, d, r, base, nxt, frac, a, b, y, acc;
            len = eff_len();
            w = wr_pos;
            if (w >= len) w = 0;
            d = d_raw;
            if (d > len * 256 - 1) d = len * 256 - 1;
            r = (w + len) * 256 - d;
            base = (r / 256) % len;
            nxt = base + 1;
            if (nxt >= len) nxt = 0;
            frac = r % 256;
            a = taps[base];
            b = taps[nxt];
            y = a + (((b - a) * frac) >>> FRAC_W);
            acc = x + ((longint'(gain) * y) >>> GAIN_SHIFT);
            if (acc > 32767) acc = 32767;
            if (acc < -32768) acc = -32768;
            taps[w] = acc[SAMPLE_W-1:0];
            w++;
            if (w >= len) w = 0;
            wr_pos = w;
            pending.push_back(y[SAMPLE_W-1:0]);
        endfunction

        function void check_result(logic [SAMPLE_W-1:0] got);
            logic [SAMPLE_W-1:0] want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected out_sample: expected none, actual %h", $time, got);
                errors++;
            end else begin
                want = pending.pop_front();
                if (got !== want) begin
                    $display("%0t: out_sample mismatch: expected %h, actual %h",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    delay_line_scoreboard sb = new();
    bit                   quiet;
    int unsigned          cycles;

    variable_feedback_delay_line #(.DEPTH(DEPTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("variable_feedback_delay_line_test: errors");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    // s_tvalid stays high across back-to-back requests.
    task automatic send_request(logic signed [SAMPLE_W-1:0] x, logic [DELAY_W-1:0] d);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - SAMPLE_W - DELAY_W){1'b0}}, d, x};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(x, d);
    endtask

    // Drain, then let the final write-back land before touching registers.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata[SAMPLE_W-1:0]);
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] lens [9];
        logic [CFG_DATA_W-1:0] gains [4];
        longint                len;
        int                    n_items, pick;
        logic [DELAY_W-1:0]    d;

        lens  = '{16'd0, 16'd2, 16'd3, 16'd5, 16'd16, 16'd100, 16'd4096, 16'd4097, 16'd0};
        gains = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0000};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        // store clearing pass holds s_tready low
        do @(posedge aclk); while (!s_tready);

        // short line, half feedback: extremes of sample and delay
        write_reg(REG_LINE_LENGTH, 16'd8);
        write_reg(REG_FEEDBACK_GAIN, 16'h4000);
        send_request(16'sh7FFF, 20'd0);
        send_request(-16'sh8000, 20'd0);
        send_request(16'sh7FFF, 20'd256);
        send_request(16'sh0001, 20'd128);
        send_request(-16'sh8000, 20'd1);
        send_request(16'sh1234, 20'd255);
        send_request(-16'sh0001, 20'd2047);
        send_request(16'sh3039, 20'hFFFFF);
        send_request(16'sh0000, 20'd2048);
        send_request(16'sh5555, 20'd0);
        send_request(-16'sh5556, 20'd384);
        send_request(16'sh7FFF, 20'd1792);
        settle();

        // length below range acts as 2; write position now lies past the line
        write_reg(REG_LINE_LENGTH, 16'd1);
        write_reg(REG_FEEDBACK_GAIN, 16'h8000);
        send_request(16'sh7FFF, 20'd0);
        send_request(16'sh7FFF, 20'd0);
        send_request(-16'sh8000, 20'd128);
        send_request(16'sh7FFF, 20'd511);
        send_request(16'sh0000, 20'hFFFFF);
        settle();

        // length above range acts as DEPTH; full gain pushes into saturation
        write_reg(REG_LINE_LENGTH, 16'h1FFF);
        write_reg(REG_FEEDBACK_GAIN, 16'h7FFF);
        send_request(16'sh7FFF, 20'd256);
        send_request(16'sh7FFF, 20'd512);
        send_request(-16'sh8000, 20'hFFFFF);
        send_request(16'sh0100, 20'd0);
        settle();

        for (int ph = 0; ph < 12; ph++) begin
            lens[8]  = CFG_DATA_W'($urandom_range(0, 8191));
            gains[3] = CFG_DATA_W'($urandom);
            write_reg(REG_LINE_LENGTH, lens[$urandom_range(0, 8)]);
            write_reg(REG_FEEDBACK_GAIN, gains[$urandom_range(0, 3)]);
            quiet   = (ph % 3 == 1);
            len     = sb.eff_len();
            n_items = $urandom_range(35, 65);
            repeat (n_items) begin
                pick = $urandom_range(0, 9);
                if (pick <= 5)      d = DELAY_W'($urandom_range(0, 32'(len * 256 - 1)));
                else if (pick == 6) d = DELAY_W'($urandom);
                else if (pick == 7) d = '0;
                else if (pick == 8) d = DELAY_W'(len * 256 - 1 - $urandom_range(0, 1));
                else                d = DELAY_W'($urandom_range(0, 511));
                send_request(SAMPLE_W'($urandom), d);
            end
            settle();
        end

        quiet = 1'b0;
        if (sb.errors == 0) begin
            $display("variable_feedback_delay_line_test: clean");
        end else begin
            $display("variable_feedback_delay_line_test: errors");
        end
        $finish;
    end
endmodule
